>>> src/mwc_pkg.sv
// Shared types and constants for the maze wall carver.
package mwc_pkg;

    localparam int SIDE_MAX = 32;
    localparam int CELL_MAX = SIDE_MAX * SIDE_MAX;
    localparam int CELL_W   = $clog2(CELL_MAX);
    localparam int COUNT_W  = CELL_W + 1;
    localparam int SIDE_W   = 6;
    localparam int ADDR_W   = 2;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VISIT = 1'b1;

    // Direction codes
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // Register addresses
    localparam logic [ADDR_W-1:0] ADDR_SIDE_LENGTH = 2'd0;

    // Wall nibbles and masks
    localparam logic [3:0] WALLS_ALL   = 4'd15;
    localparam logic [3:0] WALLS_ENTRY = 4'd11;
    localparam logic [3:0] WALLS_EXIT  = 4'd14;
    localparam logic [3:0] KEEP_LEFT   = 4'd11;
    localparam logic [3:0] KEEP_UP     = 4'd7;
    localparam logic [3:0] KEEP_RIGHT  = 4'd14;
    localparam logic [3:0] KEEP_DOWN   = 4'd13;
    localparam logic [3:0] WALL_TOP    = 4'd8;
    localparam logic [3:0] WALL_LEFT   = 4'd4;
    localparam logic [3:0] WALL_BOTTOM = 4'd2;
    localparam logic [3:0] WALL_RIGHT  = 4'd1;

    typedef struct packed {
        logic              req_type;
        logic [CELL_W-1:0] cell_index;
        logic [7:0]        try_order;
    } req_word_t;

    typedef struct packed {
        logic [3:0]         cell_walls;
        logic [CELL_W-1:0]  neighbor_index;
        logic [3:0]         neighbor_walls;
        logic               fused;
        logic [COUNT_W-1:0] sets_left;
    } rsp_word_t;

endpackage

>>> src/maze_wall_carver_union_find.sv
// Top level: maze carver with union-find over wall and parent memories.
//
// A start word sweeps the wall and parent memories one cell per cycle. A
// visit word to a cell inside the maze first runs the column divider; one to
// a cell outside it goes straight to the result. A root lookup then walks the
// parent links, once for the visited cell and once for each tried neighbor.
// A join links the roots and rewrites the two wall entries. Forcing the
// boundary walls and posting the result follow. The single read port on each
// memory and the union-find chain length set how long a visit word takes.
// Input stalls for the whole time one word is being worked on, and also while
// its result waits for the previous one to leave.
module maze_wall_carver_union_find
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  mwc_pkg::req_word_t        req_word,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output mwc_pkg::rsp_word_t        rsp_word,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [mwc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import mwc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_DIV, ST_F_RD, ST_F_WALK, ST_TRY, ST_JOIN,
        ST_WX, ST_WO, ST_BX_RD, ST_BX, ST_FIN
    } state_t;

    state_t              state_reg;
    logic [SIDE_W-1:0]   side_reg;
    logic                req_is_start_reg;
    logic [CELL_W-1:0]   x_reg;
    logic [7:0]          order_reg;
    logic [COUNT_W-1:0]  idx_reg;
    logic [3:0]          div_cnt_reg;
    logic [SIDE_W-1:0]   col_reg;
    logic [CELL_W-1:0]   find_c_reg;
    logic [COUNT_W-1:0]  steps_reg;
    logic                is_b_reg;
    logic [CELL_W-1:0]   ra_reg;
    logic [1:0]          try_reg;
    logic [CELL_W-1:0]   other_reg;
    logic [3:0]          keep_self_reg;
    logic [3:0]          keep_other_reg;
    logic [COUNT_W-1:0]  group_reg;
    logic [3:0]          cw_reg;
    logic [CELL_W-1:0]   nb_reg;
    logic [3:0]          nw_reg;
    logic                fused_reg;
    logic                rsp_valid_reg;
    rsp_word_t           rsp_word_reg;

    // Memories
    logic [3:0]        wall_mem [CELL_MAX];
    logic [CELL_W-1:0] par_mem  [CELL_MAX];
    logic [3:0]        wall_rd_reg;
    logic [CELL_W-1:0] par_rd_reg;
    logic              wall_we;
    logic [CELL_W-1:0] wall_waddr;
    logic [3:0]        wall_wdata;
    logic [CELL_W-1:0] wall_raddr;
    logic              par_we;
    logic [CELL_W-1:0] par_waddr;
    logic [CELL_W-1:0] par_wdata;
    logic [CELL_W-1:0] par_raddr;

    // Side in use and derived sizes
    logic [SIDE_W-1:0]  s_use;
    logic [COUNT_W-1:0] n_cells;
    logic [COUNT_W-1:0] n_minus_s;
    logic [COUNT_W-1:0] s_ext;
    logic               at_left, at_top, at_right, at_bottom;
    logic [6:0]         div_trial;
    logic [1:0]         dir;
    logic               skip;
    logic [CELL_W-1:0]  other;
    logic [3:0]         keep_self, keep_other;
    logic [3:0]         forced;
    logic               find_done;
    logic               accept;
    logic               cfg_write;

    always_comb
    begin
        if (side_reg < SIDE_W'(2))
            s_use = SIDE_W'(2);
        else if (side_reg > SIDE_W'(SIDE_MAX))
            s_use = SIDE_W'(SIDE_MAX);
        else
            s_use = side_reg;
    end

    assign s_ext     = COUNT_W'(s_use);
    assign n_cells   = s_ext * s_ext;
    assign n_minus_s = n_cells - s_ext;

    // Edge tests on the visited cell
    assign at_left   = (col_reg == '0);
    assign at_right  = (col_reg == s_use - SIDE_W'(1));
    assign at_top    = (COUNT_W'(x_reg) < s_ext);
    assign at_bottom = (COUNT_W'(x_reg) >= n_minus_s);

    // One restoring divide step for the column
    assign div_trial = {col_reg, x_reg[div_cnt_reg]};

    // Direction under test
    assign dir = order_reg[{try_reg, 1'b0} +: 2];

    always_comb
    begin
        unique case (dir)
            DIR_LEFT:
            begin
                skip = at_left;  other = x_reg - CELL_W'(1);
                keep_self = KEEP_LEFT;  keep_other = KEEP_RIGHT;
            end
            DIR_UP:
            begin
                skip = at_top;   other = x_reg - CELL_W'(s_use);
                keep_self = KEEP_UP;    keep_other = KEEP_DOWN;
            end
            DIR_RIGHT:
            begin
                skip = at_right; other = x_reg + CELL_W'(1);
                keep_self = KEEP_RIGHT; keep_other = KEEP_LEFT;
            end
            default:
            begin
                skip = at_bottom; other = x_reg + CELL_W'(s_use);
                keep_self = KEEP_DOWN;  keep_other = KEEP_UP;
            end
        endcase
    end

    // Boundary walls to force on the visited cell
    always_comb
    begin
        forced = '0;
        if (at_left && x_reg != '0)
            forced = forced | WALL_LEFT;
        if (at_top)
            forced = forced | WALL_TOP;
        if (at_right && COUNT_W'(x_reg) != n_cells - COUNT_W'(1))
            forced = forced | WALL_RIGHT;
        if (at_bottom)
            forced = forced | WALL_BOTTOM;
    end

    assign find_done = (par_rd_reg == find_c_reg) || (steps_reg == COUNT_W'(CELL_MAX));

    // Memory port control
    always_comb
    begin
        wall_we    = 1'b0;
        wall_waddr = x_reg;
        wall_wdata = '0;
        wall_raddr = x_reg;
        par_we     = 1'b0;
        par_waddr  = idx_reg[CELL_W-1:0];
        par_wdata  = idx_reg[CELL_W-1:0];
        par_raddr  = find_c_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                wall_we    = 1'b1;
                wall_waddr = idx_reg[CELL_W-1:0];
                if (idx_reg == '0)
                    wall_wdata = WALLS_ENTRY;
                else if (idx_reg == n_cells - COUNT_W'(1))
                    wall_wdata = WALLS_EXIT;
                else
                    wall_wdata = WALLS_ALL;
                par_we = 1'b1;
            end
            ST_F_WALK:
                par_raddr = par_rd_reg;
            ST_JOIN:
            begin
                par_we    = 1'b1;
                par_waddr = ra_reg;
                par_wdata = find_c_reg;
            end
            ST_WX:
            begin
                wall_we    = 1'b1;
                wall_wdata = wall_rd_reg & keep_self_reg;
                wall_raddr = other_reg;
            end
            ST_WO:
            begin
                wall_we    = 1'b1;
                wall_waddr = other_reg;
                wall_wdata = wall_rd_reg & keep_other_reg;
            end
            ST_BX:
            begin
                wall_we    = 1'b1;
                wall_wdata = wall_rd_reg | forced;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[wall_waddr] <= wall_wdata;
        wall_rd_reg <= wall_mem[wall_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_waddr] <= par_wdata;
        par_rd_reg <= par_mem[par_raddr];
    end

    // Handshakes
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_SIDE_LENGTH);
    assign prdata    = (paddr == ADDR_SIDE_LENGTH) ? {{(32-SIDE_W){1'b0}}, side_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= SIDE_W'(SIDE_MAX);
        else if (cfg_write)
            side_reg <= pwdata[SIDE_W-1:0];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            group_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_FIN)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_is_start_reg <= (req_word.req_type == REQ_START);
                        x_reg       <= req_word.cell_index;
                        order_reg   <= req_word.try_order;
                        idx_reg     <= '0;
                        div_cnt_reg <= 4'(CELL_W - 1);
                        col_reg     <= '0;
                        try_reg     <= '0;
                        cw_reg      <= '0;
                        nb_reg      <= '0;
                        nw_reg      <= '0;
                        fused_reg   <= 1'b0;
                        if (req_word.req_type == REQ_START)
                            state_reg <= ST_CLR;
                        else if (COUNT_W'(req_word.cell_index) >= n_cells)
                            state_reg <= ST_FIN;
                        else
                            state_reg <= ST_DIV;
                    end
                end
                ST_CLR:
                begin
                    idx_reg <= idx_reg + COUNT_W'(1);
                    if (idx_reg == n_cells - COUNT_W'(1))
                    begin
                        group_reg <= n_cells;
                        state_reg <= ST_FIN;
                    end
                end
                ST_DIV:
                begin
                    if (div_trial >= 7'(s_use))
                        col_reg <= SIDE_W'(div_trial - 7'(s_use));
                    else
                        col_reg <= div_trial[SIDE_W-1:0];
                    div_cnt_reg <= div_cnt_reg - 4'd1;
                    if (div_cnt_reg == '0)
                    begin
                        find_c_reg <= x_reg;
                        steps_reg  <= '0;
                        is_b_reg   <= 1'b0;
                        state_reg  <= ST_F_RD;
                    end
                end
                ST_F_RD:
                    state_reg <= ST_F_WALK;
                ST_F_WALK:
                begin
                    if (find_done)
                    begin
                        if (!is_b_reg)
                        begin
                            ra_reg    <= find_c_reg;
                            state_reg <= ST_TRY;
                        end
                        else if (find_c_reg != ra_reg)
                            state_reg <= ST_JOIN;
                        else if (try_reg == 2'd3)
                            state_reg <= ST_BX_RD;
                        else
                        begin
                            try_reg   <= try_reg + 2'd1;
                            state_reg <= ST_TRY;
                        end
                    end
                    else
                    begin
                        find_c_reg <= par_rd_reg;
                        steps_reg  <= steps_reg + COUNT_W'(1);
                    end
                end
                ST_TRY:
                begin
                    if (skip)
                    begin
                        if (try_reg == 2'd3)
                            state_reg <= ST_BX_RD;
                        else
                            try_reg <= try_reg + 2'd1;
                    end
                    else
                    begin
                        other_reg      <= other;
                        keep_self_reg  <= keep_self;
                        keep_other_reg <= keep_other;
                        find_c_reg     <= other;
                        steps_reg      <= '0;
                        is_b_reg       <= 1'b1;
                        state_reg      <= ST_F_RD;
                    end
                end
                ST_JOIN:
                begin
                    if (group_reg != '0)
                        group_reg <= group_reg - COUNT_W'(1);
                    state_reg <= ST_WX;
                end
                ST_WX:
                    state_reg <= ST_WO;
                ST_WO:
                begin
                    nb_reg    <= other_reg;
                    nw_reg    <= wall_rd_reg & keep_other_reg;
                    fused_reg <= 1'b1;
                    state_reg <= ST_BX_RD;
                end
                ST_BX_RD:
                    state_reg <= ST_BX;
                ST_BX:
                begin
                    cw_reg    <= wall_rd_reg | forced;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_word_reg.cell_walls     <= req_is_start_reg ? 4'd0 : cw_reg;
            rsp_word_reg.neighbor_index <= nb_reg;
            rsp_word_reg.neighbor_walls <= nw_reg;
            rsp_word_reg.fused          <= fused_reg;
            rsp_word_reg.sets_left      <= group_reg;
        end
    end

endmodule

>>> bench/maze_wall_carver_union_find_tb.sv
// Self-checking testbench for the union-find maze wall carver.
module maze_wall_carver_union_find_tb;
    import mwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        int        side;
        req_word_t word;
        bit        typed;
        rsp_word_t rsp;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp_word;
    logic      psel;
    logic      penable;
    logic      pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic      pready;

    // Shadow maze state
    logic [3:0]         maze_walls [CELL_MAX];
    logic [CELL_W-1:0]  maze_parent [CELL_MAX];
    logic [COUNT_W-1:0] maze_groups;
    logic [SIDE_W-1:0]  side_reg;

    rsp_word_t carve_q [$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        hold_req;
    bit        hold_done;

    // Side lengths walked by the random phases
    int        sides [] = '{2, 3, 4, 2, 6, 8, 3, 12, 5, 32, 2, 7};

    maze_wall_carver_union_find i_dut
    (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Directed rows: typed results only where obvious
    stim_row_t directed [] = '{
        '{2,  {REQ_START, 10'd0,    8'h00}, 1, {4'd0, 10'd0, 4'd0, 1'b0, 11'd4}},
        '{2,  {REQ_VISIT, 10'd1023, 8'h00}, 1, {4'd0, 10'd0, 4'd0, 1'b0, 11'd4}},
        '{2,  {REQ_VISIT, 10'd0,    8'h00}, 0, '0},
        '{2,  {REQ_VISIT, 10'd0,    8'hE4}, 0, '0},
        '{2,  {REQ_VISIT, 10'd3,    8'hFF}, 0, '0},
        '{2,  {REQ_VISIT, 10'd1,    8'h1B}, 0, '0},
        '{2,  {REQ_VISIT, 10'd2,    8'h4E}, 0, '0},
        '{2,  {REQ_VISIT, 10'd3,    8'hB1}, 0, '0},
        '{0,  {REQ_START, 10'd0,    8'hFF}, 1, {4'd0, 10'd0, 4'd0, 1'b0, 11'd4}},
        '{63, {REQ_START, 10'd1023, 8'h00}, 1, {4'd0, 10'd0, 4'd0, 1'b0, 11'd1024}},
        '{63, {REQ_VISIT, 10'd0,    8'hE4}, 0, '0},
        '{63, {REQ_VISIT, 10'd1023, 8'h1B}, 0, '0},
        '{63, {REQ_VISIT, 10'd1023, 8'h00}, 0, '0},
        '{63, {REQ_VISIT, 10'd31,   8'h93}, 0, '0},
        '{63, {REQ_VISIT, 10'd992,  8'h6C}, 0, '0},
        '{63, {REQ_VISIT, 10'd512,  8'h5A}, 0, '0},
        '{2,  {REQ_VISIT, 10'd0,    8'hE4}, 0, '0},
        '{2,  {REQ_VISIT, 10'd3,    8'h93}, 0, '0},
        '{1,  {REQ_START, 10'd0,    8'h00}, 1, {4'd0, 10'd0, 4'd0, 1'b0, 11'd4}},
        '{1,  {REQ_VISIT, 10'd4,    8'hE4}, 1, {4'd0, 10'd0, 4'd0, 1'b0, 11'd4}},
        '{5,  {REQ_START, 10'd0,    8'h00}, 1, {4'd0, 10'd0, 4'd0, 1'b0, 11'd25}},
        '{5,  {REQ_VISIT, 10'd24,   8'h39}, 0, '0},
        '{5,  {REQ_VISIT, 10'd12,   8'hE4}, 0, '0},
        '{5,  {REQ_VISIT, 10'd4,    8'h2D}, 0, '0}
    };

    function automatic int side_in_use();
        int s;
        s = side_reg;
        if (s < 2) s = 2;
        if (s > SIDE_MAX) s = SIDE_MAX;
        return s;
    endfunction

    function automatic int root_of(int c);
        int steps;
        steps = 0;
        while (maze_parent[c] != c && steps < CELL_MAX)
        begin
            c = maze_parent[c];
            steps++;
        end
        return c;
    endfunction

    // Advance the shadow maze by one request word
    function automatic rsp_word_t carve_cell(req_word_t w);
        rsp_word_t  r;
        int         s, n, x, other, ra, rb;
        logic [1:0] dir;
        logic [3:0] keep_self, keep_other;
        bit         skip;
        s = side_in_use();
        n = s * s;
        x = w.cell_index;
        r = '0;
        if (w.req_type == REQ_START)
        begin
            for (int i = 0; i < n; i++)
            begin
                maze_walls[i]  = WALLS_ALL;
                maze_parent[i] = CELL_W'(i);
            end
            maze_walls[0]   = WALLS_ENTRY;
            maze_walls[n-1] = WALLS_EXIT;
            maze_groups     = COUNT_W'(n);
        end
        else if (x < n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dir  = w.try_order[2*i +: 2];
                skip = 0;
                case (dir)
                    DIR_LEFT:
                    begin
                        skip = (x % s == 0);
                        other = x - 1; keep_self = KEEP_LEFT; keep_other = KEEP_RIGHT;
                    end
                    DIR_UP:
                    begin
                        skip = (x < s);
                        other = x - s; keep_self = KEEP_UP; keep_other = KEEP_DOWN;
                    end
                    DIR_RIGHT:
                    begin
                        skip = (x % s == s - 1);
                        other = x + 1; keep_self = KEEP_RIGHT; keep_other = KEEP_LEFT;
                    end
                    default:
                    begin
                        skip = (x >= n - s);
                        other = x + s; keep_self = KEEP_DOWN; keep_other = KEEP_UP;
                    end
                endcase
                if (!skip)
                begin
                    ra = root_of(x);
                    rb = root_of(other);
                    if (ra != rb)
                    begin
                        maze_parent[ra] = CELL_W'(rb);
                        if (maze_groups > 0) maze_groups--;
                        maze_walls[x]     &= keep_self;
                        maze_walls[other] &= keep_other;
                        r.neighbor_index = CELL_W'(other);
                        r.neighbor_walls = maze_walls[other];
                        r.fused = 1'b1;
                        break;
                    end
                end
            end
            // Re-close the boundary, keeping entrance and exit open
            if (x % s == 0 && x != 0) maze_walls[x] |= WALL_LEFT;
            if (x < s) maze_walls[x] |= WALL_TOP;
            if (x % s == s - 1 && x != n - 1) maze_walls[x] |= WALL_RIGHT;
            if (x >= n - s) maze_walls[x] |= WALL_BOTTOM;
            r.cell_walls = maze_walls[x];
        end
        r.sets_left = maze_groups;
        return r;
    endfunction

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (carve_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, rsp_word);
                errors++;
            end
            else
            begin
                want = carve_q.pop_front();
                if (rsp_word.cell_walls !== want.cell_walls)
                begin
                    $display("%0t: cell_walls expected %h actual %h",
                             $time, want.cell_walls, rsp_word.cell_walls);
                    errors++;
                end
                if (rsp_word.neighbor_index !== want.neighbor_index)
                begin
                    $display("%0t: neighbor_index expected %0d actual %0d",
                             $time, want.neighbor_index, rsp_word.neighbor_index);
                    errors++;
                end
                if (rsp_word.neighbor_walls !== want.neighbor_walls)
                begin
                    $display("%0t: neighbor_walls expected %h actual %h",
                             $time, want.neighbor_walls, rsp_word.neighbor_walls);
                    errors++;
                end
                if (rsp_word.fused !== want.fused)
                begin
                    $display("%0t: fused expected %b actual %b",
                             $time, want.fused, rsp_word.fused);
                    errors++;
                end
                if (rsp_word.sets_left !== want.sets_left)
                begin
                    $display("%0t: sets_left expected %0d actual %0d",
                             $time, want.sets_left, rsp_word.sets_left);
                    errors++;
                end
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stall: random bursts, plus one long hold-off on request
    initial
    begin
        int stall_len;
        rsp_stall = 1'b0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1;
            end
            else
            begin
                stall_len = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                if (stall_len > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (stall_len) @(negedge clk);
                end
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    task automatic apb_write(logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SIDE_LENGTH;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        side_reg = value[SIDE_W-1:0];
    endtask

    // Drop valid and wait until every result has come
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (carve_q.size() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Offer one word, then record its expectation once accepted
    task automatic send_word(req_word_t w, bit typed, rsp_word_t typed_rsp);
        int        gap;
        rsp_word_t got;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        got = carve_cell(w);
        carve_q = {carve_q, (typed ? typed_rsp : got)};
    endtask

    initial
    begin
        int        sent, n, pick, visits, cap;
        req_word_t w;
        hold_req  = 0;
        side_reg  = 6'd32;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_word  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        for (int i = 0; i < CELL_MAX; i++)
        begin
            maze_walls[i]  = '0;
            maze_parent[i] = '0;
        end
        maze_groups = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        for (int i = 0; i < directed.size(); i++)
        begin
            if (i == 0 || directed[i].side != directed[i-1].side)
            begin
                drain();
                apb_write(directed[i].side);
            end
            send_word(directed[i].word, directed[i].typed, directed[i].rsp);
        end

        // Random phases: mostly well-formed walks on small mazes
        sent = 0;
        pick = 0;
        while (sent < 2000)
        begin
            drain();
            apb_write(sides[pick % sides.size()]);
            pick++;
            n = side_in_use() * side_in_use();
            cap = (n > 100) ? 120 : 4 * n;
            send_word({REQ_START, 10'($urandom_range(0, 1023)), 8'($urandom)}, 0, '0);
            sent++;
            visits = 0;
            if (pick == 3) hold_req = 1;
            while (maze_groups > 1 && visits < cap)
            begin
                w.req_type   = REQ_VISIT;
                w.cell_index = 10'($urandom_range(0, n - 1));
                w.try_order  = 8'($urandom);
                if ($urandom_range(0, 99) < 6)
                    w.cell_index = (n < CELL_MAX) ? 10'($urandom_range(n, 1023))
                                                  : 10'($urandom);
                else if ($urandom_range(0, 199) == 0)
                    w.req_type = REQ_START;
                send_word(w, 0, '0);
                sent++;
                visits++;
                // Pause the sender until the block has caught up
                if (pick == 5 && visits == 10)
                begin
                    @(negedge clk);
                    req_valid <= 1'b0;
                    while (carve_q.size() != 0) @(posedge clk);
                end
            end
            // A few extra visits after the maze is complete or the visit cap is reached
            repeat ($urandom_range(0, 3))
            begin
                send_word({REQ_VISIT, 10'($urandom_range(0, n - 1)), 8'($urandom)}, 0, '0);
                sent++;
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && carve_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
src/mwc_pkg.sv
src/maze_wall_carver_union_find.sv
bench/maze_wall_carver_union_find_tb.sv
